### sv/sme_pkg.sv
package sme_pkg;
  localparam int VALUE_DEPTH  = 256;
  localparam int RETURN_DEPTH = 64;
  localparam int NUM_REGS     = 16;
  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int RGW = $clog2(NUM_REGS);

  localparam logic [4:0] OP_PUSH = 5'd0, OP_POP = 5'd1, OP_PUSHR = 5'd2, OP_POPR = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_SQRT = 5'd8,
    OP_IN = 5'd9, OP_OUT = 5'd10, OP_CALL = 5'd11, OP_RET = 5'd12, OP_JMP = 5'd13,
    OP_JB = 5'd14, OP_JBE = 5'd15, OP_JA = 5'd16, OP_JAE = 5'd17, OP_JE = 5'd18,
    OP_JNE = 5'd19;

  localparam logic [2:0] ST_OK = 3'd0, ST_BADREG = 3'd1, ST_UNDER = 3'd2, ST_OVER = 3'd3,
    ST_DIVZ = 3'd4, ST_NEGSQRT = 3'd5, ST_BADJUMP = 3'd6;

  typedef struct packed {
    logic [4:0]  opcode;
    logic signed [31:0] operand;
    logic signed [31:0] input_number;
    logic [15:0] current_pc;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic signed [31:0] out_number;
    logic        pc_load;
    logic [15:0] new_pc;
  } out_item_t;
endpackage

### sv/sme_if.sv
interface sme_in_if (input logic clk);
  logic valid;
  logic ready;
  sme_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sme_out_if (input logic clk);
  logic valid;
  logic ready;
  sme_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/stack_machine_execute_unit.sv
// channel | dir | handshake                 | payload
// in_     | in  | in_ch.valid/in_ch.ready   | opcode, operand, input_number, current_pc
// out_    | out | out_ch.valid/out_ch.ready | status, out_valid, out_number, pc_load, new_pc
// push, call, jmp, an unused opcode or an early error: accept, RD1, OUT, result register.
// ret adds RRD, one-operand instructions add RDW and EXEC, and two-operand ones add RD2,
// RDW2 and EXEC (the stack RAM is read twice). div and sqrt add the ITER loop and FIN in
// the shared shift-subtract unit. rst_n is synchronous, active low; the register file
// clears at once. The next item is taken only once the result has left, so a low
// out_ch.ready stalls the input.
module stack_machine_execute_unit (
  input logic clk,
  input logic rst_n,
  sme_in_if.sink in_ch,
  sme_out_if.source out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD1 = 4'd1, S_RD2 = 4'd2, S_EXEC = 4'd3,
    S_ITER = 4'd4, S_FIN = 4'd5, S_OUT = 4'd6, S_RRD = 4'd7, S_RDW = 4'd8, S_RDW2 = 4'd9;

  logic [3:0] state_r;
  sme_pkg::in_item_t it_r;
  logic [sme_pkg::VAW:0] vcnt_r;
  logic [sme_pkg::RAW:0] rcnt_r;
  logic [31:0] regs_r [sme_pkg::NUM_REGS];
  logic [31:0] vmem [sme_pkg::VALUE_DEPTH];
  logic [15:0] rmem [sme_pkg::RETURN_DEPTH];
  logic [31:0] vrd_r, a_r, b_r;
  logic [15:0] rrd_r;
  sme_pkg::out_item_t res_r;
  logic ovld_r;

  logic [31:0] acc_r, quo_r, rem_r, bit_r;
  logic [5:0] icnt_r;
  logic negq_r;

  logic [sme_pkg::VAW-1:0] vaddr;
  logic [4:0] op;
  logic [31:0] opd;
  logic bad_reg, opd_pos, two_op, one_op, push_op;
  logic lt_ab, lt_ba, take;

  assign op = it_r.opcode;
  assign opd = it_r.operand;
  assign bad_reg = opd[31] || (opd >= 32'(sme_pkg::NUM_REGS));
  assign opd_pos = !opd[31] && (opd != 32'd0);
  assign two_op = (op >= sme_pkg::OP_ADD && op <= sme_pkg::OP_DIV) ||
                  (op >= sme_pkg::OP_JB && op <= sme_pkg::OP_JNE);
  assign one_op = op == sme_pkg::OP_POP || op == sme_pkg::OP_POPR ||
                  op == sme_pkg::OP_SQRT || op == sme_pkg::OP_OUT;
  assign push_op = op == sme_pkg::OP_PUSH || op == sme_pkg::OP_PUSHR || op == sme_pkg::OP_IN;
  assign lt_ab = $signed(a_r) < $signed(b_r);
  assign lt_ba = $signed(b_r) < $signed(a_r);

  always_comb begin
    case (op)
      sme_pkg::OP_JB:  take = lt_ab;
      sme_pkg::OP_JBE: take = !lt_ba;
      sme_pkg::OP_JA:  take = lt_ba;
      sme_pkg::OP_JAE: take = !lt_ab;
      sme_pkg::OP_JE:  take = a_r == b_r;
      default:         take = a_r != b_r;
    endcase
  end

  // read address: top on first read, next on second
  assign vaddr = (state_r == S_RD1) ? vcnt_r[sme_pkg::VAW-1:0] - sme_pkg::VAW'(1)
                                    : vcnt_r[sme_pkg::VAW-1:0] - sme_pkg::VAW'(2);

  assign in_ch.ready = (state_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (state_r == S_RD1 || state_r == S_RD2) vrd_r <= vmem[vaddr];
    rrd_r <= rmem[rcnt_r[sme_pkg::RAW-1:0] - sme_pkg::RAW'(1)];
  end

  // shared shift-subtract step: divide (restoring) and sqrt (digit pair)
  logic [32:0] dtrial;
  logic [31:0] dnrem;
  logic [31:0] strial;
  assign dnrem = {rem_r[30:0], acc_r[31]};
  assign dtrial = {1'b0, dnrem} - {1'b0, b_r};
  assign strial = quo_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcnt_r <= '0;
      rcnt_r <= '0;
      ovld_r <= 1'b0;
      for (int i = 0; i < sme_pkg::NUM_REGS; i++) regs_r[i] <= '0;
    end else begin
      if (ovld_r && out_ch.ready) ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            it_r <= in_ch.data;
            res_r <= '0;
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          if ((op == sme_pkg::OP_PUSHR || op == sme_pkg::OP_POPR) && bad_reg) begin
            res_r.status <= sme_pkg::ST_BADREG;
            state_r <= S_OUT;
          end else if ((two_op && vcnt_r < 2) || (one_op && vcnt_r == 0) ||
                       (op == sme_pkg::OP_RET && rcnt_r == 0)) begin
            res_r.status <= sme_pkg::ST_UNDER;
            state_r <= S_OUT;
          end else if (push_op) begin
            if (vcnt_r >= (sme_pkg::VAW+1)'(sme_pkg::VALUE_DEPTH)) begin
              res_r.status <= sme_pkg::ST_OVER;
            end else begin
              vmem[vcnt_r[sme_pkg::VAW-1:0]] <= (op == sme_pkg::OP_PUSH) ? opd :
                (op == sme_pkg::OP_IN) ? it_r.input_number : regs_r[opd[sme_pkg::RGW-1:0]];
              vcnt_r <= vcnt_r + 1'b1;
            end
            state_r <= S_OUT;
          end else if (op == sme_pkg::OP_CALL) begin
            if (rcnt_r >= (sme_pkg::RAW+1)'(sme_pkg::RETURN_DEPTH)) begin
              res_r.status <= sme_pkg::ST_OVER;
            end else begin
              rmem[rcnt_r[sme_pkg::RAW-1:0]] <= it_r.current_pc;
              rcnt_r <= rcnt_r + 1'b1;
              res_r.pc_load <= 1'b1;
              res_r.new_pc <= opd[15:0];
            end
            state_r <= S_OUT;
          end else if (op == sme_pkg::OP_RET) begin
            rcnt_r <= rcnt_r - 1'b1;
            state_r <= S_RRD;
          end else if (op == sme_pkg::OP_JMP) begin
            if (opd_pos) begin
              res_r.pc_load <= 1'b1;
              res_r.new_pc <= opd[15:0];
            end else res_r.status <= sme_pkg::ST_BADJUMP;
            state_r <= S_OUT;
          end else if (two_op) begin
            state_r <= S_RD2;
          end else if (one_op) begin
            vcnt_r <= vcnt_r - 1'b1;
            state_r <= S_RDW;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_RRD: begin
          res_r.pc_load <= 1'b1;
          res_r.new_pc <= rrd_r;
          state_r <= S_OUT;
        end
        S_RD2: begin
          b_r <= vrd_r;
          vcnt_r <= vcnt_r - 2'd2;
          state_r <= S_RDW2;
        end
        S_RDW2: begin
          a_r <= vrd_r;
          state_r <= S_EXEC;
        end
        S_RDW: begin
          a_r <= vrd_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_OUT;
          case (op)
            sme_pkg::OP_POPR: regs_r[opd[sme_pkg::RGW-1:0]] <= a_r;
            sme_pkg::OP_OUT: begin
              res_r.out_valid <= 1'b1;
              res_r.out_number <= a_r;
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
              vmem[vcnt_r[sme_pkg::VAW-1:0]] <= (op == sme_pkg::OP_ADD) ? a_r + b_r :
                (op == sme_pkg::OP_SUB) ? a_r - b_r : 32'(a_r * b_r);
              vcnt_r <= vcnt_r + 1'b1;
            end
            sme_pkg::OP_DIV: begin
              if (b_r == 32'd0) res_r.status <= sme_pkg::ST_DIVZ;
              else begin
                acc_r <= a_r[31] ? 32'd0 - a_r : a_r;
                b_r <= b_r[31] ? 32'd0 - b_r : b_r;
                negq_r <= a_r[31] ^ b_r[31];
                rem_r <= '0;
                quo_r <= '0;
                icnt_r <= 6'd32;
                state_r <= S_ITER;
              end
            end
            sme_pkg::OP_SQRT: begin
              if (a_r[31]) res_r.status <= sme_pkg::ST_NEGSQRT;
              else begin
                acc_r <= a_r;
                quo_r <= '0;
                bit_r <= 32'h4000_0000;
                icnt_r <= 6'd16;
                state_r <= S_ITER;
              end
            end
            sme_pkg::OP_POP: ;
            default: begin
              if (!opd_pos) res_r.status <= sme_pkg::ST_BADJUMP;
              else if (take) begin
                res_r.pc_load <= 1'b1;
                res_r.new_pc <= opd[15:0];
              end
            end
          endcase
        end
        S_ITER: begin
          icnt_r <= icnt_r - 1'b1;
          if (op == sme_pkg::OP_DIV) begin
            acc_r <= {acc_r[30:0], 1'b0};
            if (!dtrial[32]) begin
              rem_r <= dtrial[31:0];
              quo_r <= {quo_r[30:0], 1'b1};
            end else begin
              rem_r <= dnrem;
              quo_r <= {quo_r[30:0], 1'b0};
            end
          end else begin
            if (acc_r >= strial) begin
              acc_r <= acc_r - strial;
              quo_r <= (quo_r >> 1) + bit_r;
            end else quo_r <= quo_r >> 1;
            bit_r <= bit_r >> 2;
          end
          if (icnt_r == 6'd1) state_r <= S_FIN;
        end
        S_FIN: begin
          vmem[vcnt_r[sme_pkg::VAW-1:0]] <= (op == sme_pkg::OP_DIV && negq_r) ? 32'd0 - quo_r
                                                                           : quo_r;
          vcnt_r <= vcnt_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          ovld_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class stack_machine_scoreboard;
    logic [31:0] vals[$];
    logic [15:0] rets[$];
    logic [31:0] regs[sme_pkg::NUM_REGS];
    sme_pkg::out_item_t pending[$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function logic [31:0] int_sqrt(logic [31:0] x);
      logic [31:0] r;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        if (64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b)) <= 64'(x)) r = r | (32'd1 << b);
      end
      return r;
    endfunction

    function void note_instruction(sme_pkg::in_item_t it);
      sme_pkg::out_item_t res;
      logic [31:0] a, b, opd;
      logic pos, take;
      res = '0;
      opd = it.operand;
      pos = !opd[31] && opd != 0;
      case (it.opcode)
        sme_pkg::OP_PUSH, sme_pkg::OP_IN: begin
          if (vals.size() >= sme_pkg::VALUE_DEPTH) res.status = sme_pkg::ST_OVER;
          else vals.push_back(it.opcode == sme_pkg::OP_PUSH ? opd : it.input_number);
        end
        sme_pkg::OP_POP: begin
          if (vals.size() == 0) res.status = sme_pkg::ST_UNDER;
          else void'(vals.pop_back());
        end
        sme_pkg::OP_PUSHR: begin
          if (opd[31] || opd >= sme_pkg::NUM_REGS) res.status = sme_pkg::ST_BADREG;
          else if (vals.size() >= sme_pkg::VALUE_DEPTH) res.status = sme_pkg::ST_OVER;
          else vals.push_back(regs[opd]);
        end
        sme_pkg::OP_POPR: begin
          if (opd[31] || opd >= sme_pkg::NUM_REGS) res.status = sme_pkg::ST_BADREG;
          else if (vals.size() == 0) res.status = sme_pkg::ST_UNDER;
          else regs[opd] = vals.pop_back();
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
          if (vals.size() < 2) res.status = sme_pkg::ST_UNDER;
          else begin
            b = vals.pop_back();
            a = vals.pop_back();
            case (it.opcode)
              sme_pkg::OP_ADD: vals.push_back(a + b);
              sme_pkg::OP_SUB: vals.push_back(a - b);
              sme_pkg::OP_MUL: vals.push_back(a * b);
              default: begin
                if (b == 0) res.status = sme_pkg::ST_DIVZ;
                else if (a == 32'h8000_0000 && b == 32'hffff_ffff) vals.push_back(a);
                else vals.push_back($signed(a) / $signed(b));
              end
            endcase
          end
        end
        sme_pkg::OP_SQRT: begin
          if (vals.size() == 0) res.status = sme_pkg::ST_UNDER;
          else begin
            a = vals.pop_back();
            if (a[31]) res.status = sme_pkg::ST_NEGSQRT;
            else vals.push_back(int_sqrt(a));
          end
        end
        sme_pkg::OP_OUT: begin
          if (vals.size() == 0) res.status = sme_pkg::ST_UNDER;
          else begin
            res.out_number = vals.pop_back();
            res.out_valid = 1'b1;
          end
        end
        sme_pkg::OP_CALL: begin
          if (rets.size() >= sme_pkg::RETURN_DEPTH) res.status = sme_pkg::ST_OVER;
          else begin
            rets.push_back(it.current_pc);
            res.pc_load = 1'b1;
            res.new_pc = opd[15:0];
          end
        end
        sme_pkg::OP_RET: begin
          if (rets.size() == 0) res.status = sme_pkg::ST_UNDER;
          else begin
            res.pc_load = 1'b1;
            res.new_pc = rets.pop_back();
          end
        end
        sme_pkg::OP_JMP: begin
          if (!pos) res.status = sme_pkg::ST_BADJUMP;
          else begin
            res.pc_load = 1'b1;
            res.new_pc = opd[15:0];
          end
        end
        sme_pkg::OP_JB, sme_pkg::OP_JBE, sme_pkg::OP_JA, sme_pkg::OP_JAE, sme_pkg::OP_JE,
        sme_pkg::OP_JNE: begin
          if (vals.size() < 2) res.status = sme_pkg::ST_UNDER;
          else begin
            b = vals.pop_back();
            a = vals.pop_back();
            if (!pos) res.status = sme_pkg::ST_BADJUMP;
            else begin
              case (it.opcode)
                sme_pkg::OP_JB: take = $signed(a) < $signed(b);
                sme_pkg::OP_JBE: take = $signed(a) <= $signed(b);
                sme_pkg::OP_JA: take = $signed(a) > $signed(b);
                sme_pkg::OP_JAE: take = $signed(a) >= $signed(b);
                sme_pkg::OP_JE: take = a == b;
                default: take = a != b;
              endcase
              if (take) begin
                res.pc_load = 1'b1;
                res.new_pc = opd[15:0];
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task check_result(sme_pkg::out_item_t got);
      sme_pkg::out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.out_valid !== w.out_valid) report("out_valid", got.out_valid, w.out_valid);
      if (got.out_number !== w.out_number) report("out_number", got.out_number, w.out_number);
      if (got.pc_load !== w.pc_load) report("pc_load", got.pc_load, w.pc_load);
      if (got.new_pc !== w.new_pc) report("new_pc", got.new_pc, w.new_pc);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  sme_in_if in_ch(clk);
  sme_out_if out_ch(clk);
  stack_machine_scoreboard sb = new();
  int idle_pct = 17;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;

  stack_machine_execute_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_instruction(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  task send(logic [4:0] op, logic [31:0] opd, logic [31:0] num = 0, logic [15:0] pc = 0);
    sme_pkg::in_item_t it;
    it.opcode = op;
    it.operand = opd;
    it.input_number = num;
    it.current_pc = pc;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task drain();
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(20) - 10;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task random_instr(int deep);
    logic [4:0] op;
    logic [31:0] opd;
    int r;
    r = $urandom_range(99);
    if (r < 3) op = 5'($urandom_range(31, 20));
    else if (r < 25 && deep < 200) op = sme_pkg::OP_PUSH;
    else op = 5'($urandom_range(19));
    case (op)
      sme_pkg::OP_PUSHR, sme_pkg::OP_POPR:
        opd = ($urandom_range(9) == 0) ? rand_word() : $urandom_range(15);
      sme_pkg::OP_CALL, sme_pkg::OP_JMP, sme_pkg::OP_JB, sme_pkg::OP_JBE, sme_pkg::OP_JA,
      sme_pkg::OP_JAE, sme_pkg::OP_JE, sme_pkg::OP_JNE:
        opd = ($urandom_range(7) == 0) ? rand_word() : $urandom_range(65535, 1);
      default: opd = rand_word();
    endcase
    send(op, opd, rand_word(), 16'($urandom));
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(sme_pkg::OP_POP, 0);
    send(sme_pkg::OP_ADD, 0);
    send(sme_pkg::OP_RET, 0);
    send(sme_pkg::OP_PUSH, 32'h8000_0000);
    send(sme_pkg::OP_ADD, 0);
    send(sme_pkg::OP_PUSH, 32'h8000_0000);
    send(sme_pkg::OP_PUSH, 32'hffff_ffff);
    send(sme_pkg::OP_DIV, 0);
    send(sme_pkg::OP_PUSH, 0);
    send(sme_pkg::OP_DIV, 0);
    send(sme_pkg::OP_IN, 0, 32'h7fff_ffff);
    send(sme_pkg::OP_SQRT, 0);
    send(sme_pkg::OP_OUT, 0);
    send(sme_pkg::OP_PUSH, -5);
    send(sme_pkg::OP_SQRT, 0);
    send(sme_pkg::OP_PUSHR, 16);
    send(sme_pkg::OP_POPR, -1);
    send(sme_pkg::OP_JMP, 0);
    send(sme_pkg::OP_CALL, 32'h8001_2345, 0, 16'hffff);
    send(sme_pkg::OP_RET, 0);
    send(sme_pkg::OP_JMP, 32'h0001_0007);
    send(sme_pkg::OP_PUSH, 3);
    send(sme_pkg::OP_PUSH, 3);
    send(sme_pkg::OP_JE, -7);
    send(5'd31, 0);
    drain();
    // fill both stacks to overflow
    for (int i = 0; i < sme_pkg::VALUE_DEPTH + 2; i++) send(sme_pkg::OP_IN, 0, $urandom, 0);
    for (int i = 0; i < sme_pkg::RETURN_DEPTH + 2; i++)
      send(sme_pkg::OP_CALL, $urandom, 0, 16'($urandom));
    for (int i = 0; i < sme_pkg::RETURN_DEPTH + 2; i++) send(sme_pkg::OP_RET, 0);
    for (int i = 0; i < 200; i++) random_instr(sb.vals.size());
    drain();
    hold_req = hold_req + 1;
    for (int i = 0; i < 100; i++) random_instr(sb.vals.size());
    idle_pct = 0;
    for (int i = 0; i < 300; i++) random_instr(sb.vals.size());
    idle_pct = 17;
    for (int i = 0; i < 435; i++) random_instr(sb.vals.size());
    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end
endmodule

### filelist.f
sv/sme_pkg.sv
sv/sme_if.sv
sv/stack_machine_execute_unit.sv
dv/tb_top.sv
